// File: rtl/cmrv_pkg.sv
// Shared types and constants of the cylindrical mesh ring volume block.
// Used by every module of the block; depends on nothing.
package cmrv_pkg;

  // Fixed-point format of coordinates and bounds.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int BIN_W       = 16;
  localparam int VOL_W       = 48;
  localparam int IDX_W       = 3;

  // Pi in unsigned Q2.32, rounded.
  localparam int          PI_W  = 34;
  localparam logic [33:0] PI_Q32 = 34'h3_243F_6A89;

  // Register indexes of the configuration port.
  typedef enum logic [IDX_W-1:0] {
    CFG_RADIAL_MIN  = 3'd0,
    CFG_RADIAL_MAX  = 3'd1,
    CFG_AXIAL_MIN   = 3'd2,
    CFG_AXIAL_MAX   = 3'd3,
    CFG_RADIAL_BINS = 3'd4,
    CFG_AXIAL_BINS  = 3'd5
  } cfg_idx_t;

  // One point request.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } in_t;

  // One ring volume result.
  typedef struct packed {
    logic [VOL_W-1:0] cell_volume;
    logic [BIN_W-1:0] ring_index;
    logic             inside_res;
  } out_t;

  // Status that travels beside the volume product.
  typedef struct packed {
    logic             ok;
    logic             pos;
    logic [BIN_W-1:0] idx;
  } vmeta_t;

endpackage

// File: rtl/cmrv_sqrt_cell.sv
// One bit of the digit-by-digit integer square root.
// Depends on cmrv_pkg for the coordinate width.
module cmrv_sqrt_cell import cmrv_pkg::*; #(
  parameter int BIT = 0,
  parameter int SW  = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*COORD_WIDTH-1:0] rem_i,
  input  logic [COORD_WIDTH-1:0]   res_i,
  input  logic [SW-1:0]            side_i,
  output logic [2*COORD_WIDTH-1:0] rem_o,
  output logic [COORD_WIDTH-1:0]   res_o,
  output logic [SW-1:0]            side_o
);

  localparam int CW = COORD_WIDTH;

  logic [2*CW:0] trial;
  logic          ge;

  // The bit is set when (res + 2^BIT)^2 - res^2 still fits in the remainder.
  always_comb begin
    trial = ({{(CW+1){1'b0}}, res_i} << (BIT + 1)) | ((2*CW+1)'(1) << (2 * BIT));
    ge    = {1'b0, rem_i} >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? (rem_i - trial[2*CW-1:0]) : rem_i;
      res_o  <= ge ? (res_i | (CW'(1) << BIT)) : res_i;
      side_o <= side_i;
    end
  end

endmodule

// File: rtl/cmrv_div_cell.sv
// One restoring step of several unsigned divisions side by side.
// Depends on cmrv_pkg only through the common import.
module cmrv_div_cell import cmrv_pkg::*; #(
  parameter int LANES = 1,
  parameter int DW    = 16,
  parameter int QW    = 16,
  parameter int SW    = 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [LANES-1:0][DW-1:0]  div_i,
  input  logic [LANES-1:0][DW-1:0]  rem_i,
  input  logic [LANES-1:0][QW-1:0]  nq_i,
  input  logic [SW-1:0]             side_i,
  output logic [LANES-1:0][DW-1:0]  rem_o,
  output logic [LANES-1:0][QW-1:0]  nq_o,
  output logic [SW-1:0]             side_o
);

  logic [LANES-1:0][DW:0] t;
  logic [LANES-1:0][DW:0] diff;
  logic [LANES-1:0]       ge;

  // Shift the next numerator bit into the remainder and try the divisor.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      t[l]    = {rem_i[l], nq_i[l][QW-1]};
      ge[l]   = t[l] >= {1'b0, div_i[l]};
      diff[l] = t[l] - {1'b0, div_i[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem_o[l] <= ge[l] ? diff[l][DW-1:0] : t[l][DW-1:0];
        nq_o[l]  <= {nq_i[l][QW-2:0], ge[l]};
      end
      side_o <= side_i;
    end
  end

endmodule

// File: rtl/cylindrical_mesh_ring_volume.sv
// Top level of the cylindrical mesh ring volume block.
// Depends on cmrv_pkg, cmrv_sqrt_cell and cmrv_div_cell.

// The block takes one point per clock while no result is stalled and returns
// one result per point, in order. The chain holds 32 square-root cells for
// the radius, 16 division cells for the ring search, 48 division cells for
// the ring boundaries and slice height, and four partial-product stages for
// the volume. A stall on the result side holds the whole chain, so in_stall
// follows out_stall while a result is waiting. Configuration registers should
// be written only while no request is in flight.
module cylindrical_mesh_ring_volume import cmrv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int BW  = BIN_W;
  localparam int NW  = CW + BW;
  localparam int MW  = CW + 2;
  localparam int DH  = (MW + 1) / 2;
  localparam int HPW = CW + PI_W;
  localparam int NCH = (HPW + DH - 1) / DH;
  localparam int HCW = NCH * DH;
  localparam int WDW = 2 * MW;
  localparam int PW  = WDW + HCW;
  localparam int VSH = 2 * FRAC_BITS + 32;
  localparam int LAT = 3 + CW + 2 + BW + 2 + NW + 3 + NCH + 1;

  // Configuration registers.
  logic signed [CW-1:0] rmin_r, rmax_r, amin_r, amax_r;
  logic [BW-1:0]        rbins_r, abins_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmin_r  <= '0;
      rmax_r  <= CW'(1) << FRAC_BITS;
      amin_r  <= '0;
      amax_r  <= CW'(1) << FRAC_BITS;
      rbins_r <= BW'(1);
      abins_r <= BW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIAL_MIN:  rmin_r  <= cfg_data;
        CFG_RADIAL_MAX:  rmax_r  <= cfg_data;
        CFG_AXIAL_MIN:   amin_r  <= cfg_data;
        CFG_AXIAL_MAX:   amax_r  <= cfg_data;
        CFG_RADIAL_BINS: rbins_r <= cfg_data[BW-1:0];
        CFG_AXIAL_BINS:  abins_r <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  // Values that follow from the configuration alone.
  logic signed [CW:0] span, neg_span, zspan;
  logic               span_pos;
  logic [CW-1:0]      s_div, m_val;
  logic [BW-1:0]      n0, n2;

  always_comb begin
    span     = {rmax_r[CW-1], rmax_r} - {rmin_r[CW-1], rmin_r};
    neg_span = -span;
    zspan    = {amax_r[CW-1], amax_r} - {amin_r[CW-1], amin_r};
    span_pos = !span[CW] && (span != '0);
    s_div    = span_pos ? span[CW-1:0] : CW'(1);
    m_val    = neg_span[CW-1:0];
    n0       = (rbins_r == '0) ? BW'(1) : rbins_r;
    n2       = (abins_r == '0) ? BW'(1) : abins_r;
  end

  // Global advance: the chain moves unless a result waits on a stall.
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Magnitudes and the axial test.
  logic [CW-1:0] mx_r, my_r;
  logic          zok0_r, zok1_r, zok2_r;
  logic [2*CW-1:0] xx_r, yy_r, nsum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r   <= in_data.pos_x[CW-1] ? (~in_data.pos_x + CW'(1)) : in_data.pos_x;
      my_r   <= in_data.pos_y[CW-1] ? (~in_data.pos_y + CW'(1)) : in_data.pos_y;
      zok0_r <= (in_data.pos_z >= amin_r) && (in_data.pos_z < amax_r);
      xx_r   <= {{CW{1'b0}}, mx_r} * {{CW{1'b0}}, mx_r};
      yy_r   <= {{CW{1'b0}}, my_r} * {{CW{1'b0}}, my_r};
      zok1_r <= zok0_r;
      nsum_r <= xx_r + yy_r;
      zok2_r <= zok1_r;
    end
  end

  // Square-root chain, one result bit per cell from the top.
  logic [2*CW-1:0] sq_rem  [0:CW];
  logic [CW-1:0]   sq_res  [0:CW];
  logic            sq_side [0:CW];

  assign sq_rem[0]  = nsum_r;
  assign sq_res[0]  = '0;
  assign sq_side[0] = zok2_r;

  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    cmrv_sqrt_cell #(.BIT(CW - 1 - k), .SW(1)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (sq_rem[k]),
      .res_i  (sq_res[k]),
      .side_i (sq_side[k]),
      .rem_o  (sq_rem[k+1]),
      .res_o  (sq_res[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // Radial bounds test and the scaled distance from the inner radius.
  logic signed [CW:0] rad_e, a_e, b_e;
  logic               rok;
  logic [CW:0]        dist_full;
  logic               ok1_r, ok2_r;
  logic [CW-1:0]      dist_r;
  logic [NW-1:0]      numer_r;

  always_comb begin
    rad_e     = {1'b0, sq_res[CW]};
    a_e       = {rmin_r[CW-1], rmin_r};
    b_e       = {rmax_r[CW-1], rmax_r};
    rok       = !span_pos || ((rad_e >= a_e) && (rad_e < b_e));
    dist_full = rad_e - a_e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1_r   <= sq_side[CW] && rok;
      dist_r  <= dist_full[CW-1:0];
      ok2_r   <= ok1_r;
      numer_r <= span_pos ? ({{BW{1'b0}}, dist_r} * {{CW{1'b0}}, n0}) : '0;
    end
  end

  // Ring search: floor(distance * bins / span), one quotient bit per cell.
  logic [0:0][CW-1:0] ix_rem  [0:BW];
  logic [0:0][BW-1:0] ix_nq   [0:BW];
  logic               ix_side [0:BW];
  logic [0:0][CW-1:0] ix_div;

  assign ix_div[0]    = s_div;
  assign ix_rem[0][0] = numer_r[NW-1:BW];
  assign ix_nq[0][0]  = numer_r[BW-1:0];
  assign ix_side[0]   = ok2_r;

  for (genvar k = 0; k < BW; k++) begin : g_idx
    cmrv_div_cell #(.LANES(1), .DW(CW), .QW(BW), .SW(1)) u_cell (
      .clk    (clk),
      .en     (en),
      .div_i  (ix_div),
      .rem_i  (ix_rem[k]),
      .nq_i   (ix_nq[k]),
      .side_i (ix_side[k]),
      .rem_o  (ix_rem[k+1]),
      .nq_o   (ix_nq[k+1]),
      .side_o (ix_side[k+1])
    );
  end

  // Numerators of the two ring boundaries and of the slice height.
  logic [BW-1:0] idx1_r, idx2_r;
  logic          ok3_r, ok4_r;
  logic [NW-1:0] prod_r, num0_r, num1_r, hnum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= ix_nq[BW][0];
      ok3_r  <= ix_side[BW];
      prod_r <= {{CW{1'b0}}, ix_nq[BW][0]} * {{BW{1'b0}}, s_div};
      idx2_r <= idx1_r;
      ok4_r  <= ok3_r;
      num0_r <= span_pos ? prod_r : '0;
      num1_r <= span_pos ? (prod_r + {{BW{1'b0}}, s_div})
                         : ({{BW{1'b0}}, m_val} + {{CW{1'b0}}, n0} - NW'(1));
      hnum_r <= {{BW{1'b0}}, zspan[CW-1:0]};
    end
  end

  // Three divisions side by side: two boundaries by the ring count and the
  // axial span by the slice count.
  logic [2:0][BW-1:0] rg_rem  [0:NW];
  logic [2:0][NW-1:0] rg_nq   [0:NW];
  logic [BW:0]        rg_side [0:NW];
  logic [2:0][BW-1:0] rg_div;

  assign rg_div     = {n2, n0, n0};
  assign rg_rem[0]  = '0;
  assign rg_nq[0]   = {hnum_r, num1_r, num0_r};
  assign rg_side[0] = {ok4_r, idx2_r};

  for (genvar k = 0; k < NW; k++) begin : g_ring
    cmrv_div_cell #(.LANES(3), .DW(BW), .QW(NW), .SW(BW + 1)) u_cell (
      .clk    (clk),
      .en     (en),
      .div_i  (rg_div),
      .rem_i  (rg_rem[k]),
      .nq_i   (rg_nq[k]),
      .side_i (rg_side[k]),
      .rem_o  (rg_rem[k+1]),
      .nq_o   (rg_nq[k+1]),
      .side_o (rg_side[k+1])
    );
  end

  // Ring width and ring sum, their magnitudes, the area sign and height times pi.
  logic signed [CW+2:0] a_x, q0_x, q1_x, r0, r1, w_s, d_s;
  logic [CW+2:0]        w_m, d_m;
  logic [CW-1:0]        h_val;
  logic [MW-1:0]        wm_r, dm_r;
  logic [HCW-1:0]       hp_h_r, hp_i_r, hp_j_r;
  vmeta_t               mt_h_r, mt_i_r, mt_j_r;

  always_comb begin
    a_x   = {{3{rmin_r[CW-1]}}, rmin_r};
    q0_x  = {3'b000, rg_nq[NW][0][CW-1:0]};
    q1_x  = {3'b000, rg_nq[NW][1][CW-1:0]};
    h_val = rg_nq[NW][2][CW-1:0];
    r0    = span_pos ? (a_x + q0_x) : a_x;
    r1    = span_pos ? (a_x + q1_x) : (a_x - q1_x);
    w_s   = r1 - r0;
    d_s   = r1 + r0;
    w_m   = w_s[CW+2] ? -w_s : w_s;
    d_m   = d_s[CW+2] ? -d_s : d_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wm_r       <= w_m[MW-1:0];
      dm_r       <= d_m[MW-1:0];
      hp_h_r     <= {{(HCW-CW){1'b0}}, h_val} * {{(HCW-PI_W){1'b0}}, PI_Q32};
      mt_h_r.ok  <= rg_side[NW][BW];
      mt_h_r.idx <= rg_side[NW][BW-1:0];
      mt_h_r.pos <= (w_s != '0) && (d_s != '0) && (w_s[CW+2] == d_s[CW+2]);
    end
  end

  // Width times sum, in two halves of the sum.
  logic [MW+DH-1:0]      wdl_r;
  logic [2*MW-DH-1:0]    wdh_r;
  logic [WDW-1:0]        wd_j_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wdl_r  <= {{DH{1'b0}}, wm_r} * {{MW{1'b0}}, dm_r[DH-1:0]};
      wdh_r  <= {{(MW-DH){1'b0}}, wm_r} * {{MW{1'b0}}, dm_r[MW-1:DH]};
      hp_i_r <= hp_h_r;
      mt_i_r <= mt_h_r;
      wd_j_r <= WDW'(wdl_r) + (WDW'(wdh_r) << DH);
      hp_j_r <= hp_i_r;
      mt_j_r <= mt_i_r;
    end
  end

  // Volume product, one chunk of height times pi per stage.
  logic [PW-1:0]  acc_r [0:NCH-1];
  logic [WDW-1:0] wd_r  [0:NCH-1];
  logic [HCW-1:0] hp_r  [0:NCH-1];
  vmeta_t         mt_r  [0:NCH-1];

  for (genvar k = 0; k < NCH; k++) begin : g_mul
    logic [PW-1:0]      acc_in;
    logic [WDW-1:0]     wd_in;
    logic [HCW-1:0]     hp_in;
    vmeta_t             mt_in;
    logic [WDW+DH-1:0]  pp;

    if (k == 0) begin : g_first
      assign acc_in = '0;
      assign wd_in  = wd_j_r;
      assign hp_in  = hp_j_r;
      assign mt_in  = mt_j_r;
    end else begin : g_next
      assign acc_in = acc_r[k-1];
      assign wd_in  = wd_r[k-1];
      assign hp_in  = hp_r[k-1];
      assign mt_in  = mt_r[k-1];
    end

    assign pp = {{DH{1'b0}}, wd_in} * {{WDW{1'b0}}, hp_in[k*DH +: DH]};

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k] <= acc_in + (PW'(pp) << (k * DH));
        wd_r[k]  <= wd_in;
        hp_r[k]  <= hp_in;
        mt_r[k]  <= mt_in;
      end
    end
  end

  // Output register: scale, saturate and clear the fields of an outside point.
  vmeta_t         mt_f;
  logic [PW-1:0]  acc_f;
  logic [VOL_W-1:0] vol;
  out_t           out_r;

  always_comb begin
    mt_f  = mt_r[NCH-1];
    acc_f = acc_r[NCH-1];
    if (!(mt_f.ok && mt_f.pos)) begin
      vol = '0;
    end else if (|acc_f[PW-1:VSH+VOL_W]) begin
      vol = '1;
    end else begin
      vol = acc_f[VSH +: VOL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.cell_volume <= vol;
      out_r.ring_index  <= mt_f.ok ? mt_f.idx : '0;
      out_r.inside_res  <= mt_f.ok;
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/cmrv_checker.sv
// Port-level checks of the cylindrical mesh ring volume block.
// Depends on cmrv_pkg; bound to the top level at the end of this file.
module cmrv_checker import cmrv_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The request side is held only while a result waits.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("request stall does not follow the result stall");

  // A point outside the mesh carries no volume and no ring.
  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_res |->
      (out_data.cell_volume == '0) && (out_data.ring_index == '0))
    else $error("outside point with non-zero fields");

endmodule

bind cylindrical_mesh_ring_volume cmrv_checker u_cmrv_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the cylindrical mesh ring volume block.
// Depends on cmrv_pkg and cylindrical_mesh_ring_volume from the rtl folder.
`timescale 1ns / 100ps

module tb;
  import cmrv_pkg::*;

  localparam int  LATENCY     = 111;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  RAND_ITEMS  = 127;
  localparam logic [255:0] MAX128 = {128'd0, {128{1'b1}}};
  localparam logic [255:0] MAX48  = {208'd0, {48{1'b1}}};

  // Keeps the mesh settings and the results still owed by the block.
  class ring_book;
    logic [31:0] regs [6];
    out_t        owed [$];

    function new();
      regs[CFG_RADIAL_MIN]  = 32'd0;
      regs[CFG_RADIAL_MAX]  = 32'h0001_0000;
      regs[CFG_AXIAL_MIN]   = 32'd0;
      regs[CFG_AXIAL_MAX]   = 32'h0001_0000;
      regs[CFG_RADIAL_BINS] = 32'd1;
      regs[CFG_AXIAL_BINS]  = 32'd1;
    endfunction

    function void set_reg(cfg_idx_t i, logic [31:0] v);
      if (i == CFG_RADIAL_BINS || i == CFG_AXIAL_BINS) regs[i] = {16'd0, v[15:0]};
      else regs[i] = v;
    endfunction

    // Ring lookup and volume of one point.
    function out_t ring_volume(in_t p);
      out_t r;
      longint x, y, z, a, b, zl, zh, span, rad, r0, r1, w, d, m;
      logic [127:0] n0, n2, sq, res, c, dst, s, idx;
      logic [255:0] prod, hgt;
      r = '0;
      x = longint'(p.pos_x);
      y = longint'(p.pos_y);
      z = longint'(p.pos_z);
      a = longint'($signed(regs[CFG_RADIAL_MIN]));
      b = longint'($signed(regs[CFG_RADIAL_MAX]));
      zl = longint'($signed(regs[CFG_AXIAL_MIN]));
      zh = longint'($signed(regs[CFG_AXIAL_MAX]));
      n0 = (regs[CFG_RADIAL_BINS] == 0) ? 128'd1 : 128'(regs[CFG_RADIAL_BINS]);
      n2 = (regs[CFG_AXIAL_BINS] == 0) ? 128'd1 : 128'(regs[CFG_AXIAL_BINS]);
      span = b - a;
      idx = '0;
      if (z < zl || z >= zh) return r;
      if (span > 0) begin
        if (x < 0) x = -x;
        if (y < 0) y = -y;
        sq = 128'(x) * 128'(x) + 128'(y) * 128'(y);
        res = '0;
        for (int bt = 31; bt >= 0; bt--) begin
          c = res | (128'd1 << bt);
          if (c * c <= sq) res = c;
        end
        rad = longint'(res);
        if (rad < a || rad >= b) return r;
        dst = 128'(rad - a);
        s = 128'(span);
        for (int bt = 15; bt >= 0; bt--) begin
          c = idx | (128'd1 << bt);
          if (c < n0 && c * s <= dst * n0) idx = c;
        end
        r0 = a + longint'((idx * s) / n0);
        r1 = a + longint'(((idx + 1) * s) / n0);
      end else begin
        m = -span;
        r0 = a;
        r1 = a - longint'((128'(m) + n0 - 1) / n0);
      end
      w = r1 - r0;
      d = r1 + r0;
      if (w != 0 && d != 0 && ((w < 0) == (d < 0))) begin
        if (w < 0) w = -w;
        if (d < 0) d = -d;
        hgt = 256'(128'(zh - zl) / n2);
        prod = 256'(w) * 256'(d) * hgt;
        if (prod > MAX128) prod = MAX128;
        prod = prod * 256'(PI_Q32);
        if (prod > MAX128) prod = MAX128;
        prod = prod >> (2 * FRAC_BITS + 32);
        if (prod > MAX48) prod = MAX48;
        r.cell_volume = prod[VOL_W-1:0];
      end
      r.ring_index = idx[BIN_W-1:0];
      r.inside_res = 1'b1;
      return r;
    endfunction

    function void note_request(in_t p);
      owed.push_back(ring_volume(p));
    endfunction

    // Returns 1 when the result matches the oldest owed one.
    function bit check_result(out_t got, output string why);
      out_t e;
      if (owed.size() == 0) begin
        why = "result with nothing expected";
        return 0;
      end
      e = owed.pop_front();
      why = "";
      if (got.cell_volume !== e.cell_volume)
        why = {why, $sformatf(" cell_volume %0h/%0h", got.cell_volume, e.cell_volume)};
      if (got.ring_index !== e.ring_index)
        why = {why, $sformatf(" ring_index %0d/%0d", got.ring_index, e.ring_index)};
      if (got.inside_res !== e.inside_res)
        why = {why, $sformatf(" inside_res %0b/%0b", got.inside_res, e.inside_res)};
      return why == "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data = '0;

  ring_book book = new();
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;

  cylindrical_mesh_ring_volume dut (.*);

  always #10 clk = ~clk;

  task automatic report(string msg);
    $display("mismatch at cycle %0d:%s", cycles, msg);
    errors++;
  endtask

  // Note accepted requests and check accepted results.
  always @(posedge clk) begin
    string why;
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) book.note_request(in_data);
    if (rst_n && out_valid && !out_stall)
      if (!book.check_result(out_data, why)) report(why);
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result-side stalls in random bursts.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!quiet && burst == 0 && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 15);
      if (quiet) burst = 0;
      out_stall <= (burst > 0);
      if (burst > 0) burst--;
    end
  end

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_valid <= 1'b1;
    in_data <= '{pos_x: x, pos_y: y, pos_z: z};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(cfg_idx_t i, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_reg(i, v);
  endtask

  // Wait until every owed result is back and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_mesh(logic [31:0] rmin, logic [31:0] rmax, logic [31:0] zmin,
                          logic [31:0] zmax, logic [31:0] rb, logic [31:0] zb);
    write_reg(CFG_RADIAL_MIN, rmin);
    write_reg(CFG_RADIAL_MAX, rmax);
    write_reg(CFG_AXIAL_MIN, zmin);
    write_reg(CFG_AXIAL_MAX, zmax);
    write_reg(CFG_RADIAL_BINS, rb);
    write_reg(CFG_AXIAL_BINS, zb);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick(longint lo, longint hi);
    if (hi - lo >= 64'hFFFF_FFFF) return $urandom;
    return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  // Mostly points in a box around the current mesh bounds, the rest raw noise.
  task automatic random_points(int count);
    longint a, b, zl, zh, rr;
    a = longint'($signed(book.regs[CFG_RADIAL_MIN]));
    b = longint'($signed(book.regs[CFG_RADIAL_MAX]));
    zl = longint'($signed(book.regs[CFG_AXIAL_MIN]));
    zh = longint'($signed(book.regs[CFG_AXIAL_MAX]));
    rr = (a < 0) ? -a : a;
    if (b > rr) rr = b;
    if (-b > rr) rr = -b;
    if (rr > 64'h7FFF_FFFF) rr = 64'h7FFF_FFFF;
    if (zh <= zl) zh = zl + 1;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) send($urandom, $urandom, $urandom);
      else send(pick(-rr, rr), pick(-rr, rr), pick(zl, zh - 1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset mesh: unit radius, unit height, one ring.
    send(32'h0, 32'h0, 32'h0);
    send(32'h8000, 32'h0, 32'h8000);
    send(32'hB504, 32'hB504, 32'h0);
    send(32'h1_0000, 32'h0, 32'h0);
    send(32'h0, 32'hFFFF_0000, 32'h100);
    send(32'h0, 32'h0, 32'h1_0000);
    send(32'h0, 32'h0, 32'hFFFF_FFFF);
    send(32'h0, 32'h0, 32'hFFFF);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h8000_0000, 32'h0, 32'h0);
    send(32'hFFFF_FFFF, 32'h1, 32'h0);
    random_points(RAND_ITEMS);
    drain();

    // Many rings and slices, centred axial range.
    set_mesh(32'h0, 32'h64_0000, 32'hFFCE_0000, 32'h32_0000, 32'd10, 32'd4);
    send(32'h63_FFFF, 32'h0, 32'h0);
    send(32'h64_0000, 32'h0, 32'h0);
    send(32'h0, 32'h0, 32'hFFCE_0000);
    random_points(RAND_ITEMS);
    drain();

    // Thin annulus with the largest bin counts.
    set_mesh(32'hA_0000, 32'h14_0000, 32'h0, 32'h3_0000, 32'd65535, 32'd65535);
    send(32'hA_0000, 32'h0, 32'h0);
    send(32'h9_FFFF, 32'h0, 32'h0);
    random_points(RAND_ITEMS);
    drain();

    // Negative inner radius: rings whose area comes out zero or negative.
    set_mesh(32'hFFFB_0000, 32'h5_0000, 32'hFFFF_0000, 32'h1_0000, 32'd3, 32'd2);
    send(32'h0, 32'h0, 32'h0);
    random_points(RAND_ITEMS);
    drain();

    // Radial span not positive, zero axial bin count.
    set_mesh(32'h3_0000, 32'h1_0000, 32'hFFFF_0000, 32'h1_0000, 32'd3, 32'd0);
    send(32'h7FFF_FFFF, 32'h0, 32'h0);
    random_points(RAND_ITEMS);
    drain();
    set_mesh(32'h1_0000, 32'h1_0000, 32'hFFFF_0000, 32'h1_0000, 32'd0, 32'd7);
    random_points(40);
    drain();

    // Full-range mesh, saturating volumes.
    set_mesh(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1);
    send(32'h0, 32'h0, 32'h8000_0000);
    send(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFE);
    random_points(RAND_ITEMS);
    drain();

    // Large outer radius, zero radial bin count; no idling from here on.
    quiet = 1'b1;
    set_mesh(32'h0, 32'h7FFF_0000, 32'h8000_0000, 32'h0, 32'd0, 32'd65535);
    random_points(RAND_ITEMS);
    drain();

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cmrv_pkg.sv
rtl/cmrv_sqrt_cell.sv
rtl/cmrv_div_cell.sv
rtl/cylindrical_mesh_ring_volume.sv
rtl/cmrv_checker.sv
tb/tb.sv
